### rtl/srsi_pkg.sv
// Shared types and constants for the sorted range set insert block.
`default_nettype none

package srsi_pkg;

    localparam int START_W = 32;
    localparam int END_W   = 32;
    localparam int TAG_W   = 20;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    // Input tdata width: start, end, tag, padded to whole bytes
    localparam int IN_FIELDS_W = START_W + END_W + TAG_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    // Output tdata width: slot, entry count, padded to whole bytes
    localparam int OUT_FIELDS_W = SLOT_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_APPEND = 3'd0,
        ST_INSERT = 3'd1,
        ST_DUP    = 3'd2,
        ST_FULL   = 3'd3,
        ST_CLEAR  = 3'd4
    } status_t;

    // Finished result handed from the controller to the output register
    typedef struct packed
    {
        logic                 valid;
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } res_t;

endpackage

`default_nettype wire

### rtl/srsi_table_mem.sv
// Entry table: one write port, one read port, registered read data.
`default_nettype none

module srsi_table_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 84
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/srsi_ctrl.sv
// Insert sequencer: tail check, binary search, shift-up and placement.
`default_nettype none

module srsi_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int TAG_BITS    = 20,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
    parameter int MEM_W       = srsi_pkg::START_W + srsi_pkg::END_W + TAG_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire srsi_pkg::op_t                 in_op,
    input  wire logic [srsi_pkg::START_W-1:0]  in_start,
    input  wire logic [srsi_pkg::END_W-1:0]    in_end,
    input  wire logic [srsi_pkg::TAG_W-1:0]    in_tag,
    output srsi_pkg::res_t                     res,
    input  wire logic                          res_ack,
    output logic                               mem_wr_en,
    output logic [IDX_W-1:0]                   mem_wr_addr,
    output logic [MEM_W-1:0]                   mem_wr_data,
    output logic                               mem_rd_en,
    output logic [IDX_W-1:0]                   mem_rd_addr,
    input  wire logic [MEM_W-1:0]              mem_rd_data
);

    import srsi_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_LAST,
        S_PROBE,
        S_MID,
        S_CHK1,
        S_CHK2A,
        S_CHK2B,
        S_SHIFT_START,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [START_W-1:0]   key_reg, key_next;
    logic [END_W-1:0]     end_reg, end_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 lt_lo_reg, lt_lo_next;
    status_t              status_reg, status_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic [START_W-1:0]   rd_start;
    logic [END_W-1:0]     rd_end;
    logic [IDX_W-1:0]     span;
    logic [IDX_W-1:0]     mid;
    logic [IDX_W-1:0]     last_idx;
    logic                 key_eq;
    logic                 key_lt;

    assign rd_start = mem_rd_data[START_W-1:0];
    assign rd_end   = mem_rd_data[START_W +: END_W];
    assign span     = hi_reg - lo_reg;
    assign mid      = lo_reg + (span >> 1);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign key_eq   = (key_reg == rd_start);
    assign key_lt   = (key_reg < rd_start);

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        end_next    = end_reg;
        tag_next    = tag_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ptr_next    = ptr_reg;
        slot_next   = slot_reg;
        lt_lo_next  = lt_lo_reg;
        status_next = status_reg;
        count_next  = count_reg;

        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ptr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_reg;
        mem_wr_data = {tag_reg, end_reg, key_reg};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next = in_start;
                    end_next = in_end;
                    tag_next = TAG_BITS'(in_tag);
                    if (in_op == OP_CLEAR)
                    begin
                        count_next  = '0;
                        slot_next   = '0;
                        status_next = ST_CLEAR;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        slot_next   = '0;
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        slot_next   = '0;
                        status_next = ST_APPEND;
                        state_next  = S_PLACE;
                    end
                    else
                    begin
                        // fetch the tail entry to test for a plain append
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = last_idx;
                        state_next  = S_LAST;
                    end
                end
            end

            S_LAST:
            begin
                if (key_reg >= rd_end)
                begin
                    slot_next   = IDX_W'(count_reg);
                    status_next = ST_APPEND;
                    state_next  = S_PLACE;
                end
                else
                begin
                    lo_next     = '0;
                    hi_next     = last_idx;
                    status_next = ST_INSERT;
                    state_next  = S_PROBE;
                end
            end

            S_PROBE:
            begin
                mem_rd_en = 1'b1;
                if (span == '0)
                begin
                    mem_rd_addr = lo_reg;
                    state_next  = S_CHK1;
                end
                else if (span == IDX_W'(1))
                begin
                    mem_rd_addr = lo_reg;
                    state_next  = S_CHK2A;
                end
                else
                begin
                    mem_rd_addr = mid;
                    ptr_next    = mid;
                    state_next  = S_MID;
                end
            end

            S_MID:
            begin
                if (key_eq)
                begin
                    slot_next   = ptr_reg;
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (key_lt)
                    begin
                        hi_next = ptr_reg;
                    end
                    else
                    begin
                        lo_next = ptr_reg;
                    end
                    state_next = S_PROBE;
                end
            end

            S_CHK1:
            begin
                if (key_eq)
                begin
                    slot_next   = lo_reg;
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    slot_next  = key_lt ? lo_reg : lo_reg + IDX_W'(1);
                    state_next = S_SHIFT_START;
                end
            end

            S_CHK2A:
            begin
                if (key_eq)
                begin
                    slot_next   = lo_reg;
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    lt_lo_next  = key_lt;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = hi_reg;
                    state_next  = S_CHK2B;
                end
            end

            S_CHK2B:
            begin
                if (key_eq)
                begin
                    slot_next   = hi_reg;
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (lt_lo_reg)
                    begin
                        slot_next = lo_reg;
                    end
                    else if (key_lt)
                    begin
                        slot_next = hi_reg;
                    end
                    else
                    begin
                        slot_next = hi_reg + IDX_W'(1);
                    end
                    state_next = S_SHIFT_START;
                end
            end

            S_SHIFT_START:
            begin
                if (slot_reg == IDX_W'(count_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    // move entries up from the tail down to the slot
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = last_idx;
                    ptr_next    = last_idx;
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg + IDX_W'(1);
                mem_wr_data = mem_rd_data;
                if (ptr_reg == slot_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg - IDX_W'(1);
                    ptr_next    = ptr_reg - IDX_W'(1);
                end
            end

            S_PLACE:
            begin
                mem_wr_en  = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        end_reg    <= end_next;
        tag_reg    <= tag_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        lt_lo_reg  <= lt_lo_next;
        status_reg <= status_next;
    end

    assign res.valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.slot   = SLOT_W'(slot_reg);
    assign res.count  = COUNT_W'(count_reg);

endmodule

`default_nettype wire

### rtl/sorted_range_set_insert_core.sv
// Top level: stream ports, output register, sequencer and entry table.
//
//  channel  | dir | tdata (low bit first)                | tuser
//  s_axis   | in  | entry_start, entry_end, entry_tag    | operation
//  m_axis   | out | slot, entry_count                    | status
//
// Clear and full drop finish without a table access. Insert into an empty
// table writes slot 0 directly. Append follows one read of the tail entry.
// Mid-table insert or duplicate: one table read per search probe (about
// log2 of the count probes), the end checks, then the entries shifted up one
// at a time from the tail down to the slot, then placement of the new entry.
// One item is in work at a time; the single table read port sets the pace.
// Reset empties the table at once (count only, no sweep). A stalled result
// waits in the output register while the next transfer is already taken;
// a second finished result holds the sequencer, and s_axis_tready, low.
`default_nettype none

module sorted_range_set_insert_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int TAG_BITS    = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // entry_start[31:0], entry_end[63:32], entry_tag[83:64], zero pad
    input  wire logic [srsi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // slot[9:0], entry_count[20:10], zero pad
    output logic [srsi_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status
    output logic [2:0]                             m_axis_tuser
);

    import srsi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_W = START_W + END_W + TAG_BITS;

    res_t               res;
    logic               res_ack;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [MEM_W-1:0]   mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [MEM_W-1:0]   mem_rd_data;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COUNT_W-1:0] out_count_reg;

    srsi_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .MEM_W       (MEM_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (op_t'(s_axis_tuser)),
        .in_start    (s_axis_tdata[START_W-1:0]),
        .in_end      (s_axis_tdata[START_W +: END_W]),
        .in_tag      (s_axis_tdata[START_W + END_W +: TAG_W]),
        .res         (res),
        .res_ack     (res_ack),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    srsi_table_mem #(
        .DEPTH   (TABLE_DEPTH),
        .WIDTH   (MEM_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register loads when empty or drained in the same cycle
    assign res_ack = res.valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_status_reg <= res.status;
            out_slot_reg   <= res.slot;
            out_count_reg  <= res.count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_count_reg, out_slot_reg});

endmodule

`default_nettype wire

### rtl/srsi_checker.sv
// Port-level checks for the sorted range set insert core, with its bind.
`default_nettype none

module srsi_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [srsi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic [2:0]                        m_axis_tuser
);

    import srsi_pkg::*;

    logic [SLOT_W-1:0]  out_slot;
    logic [COUNT_W-1:0] out_count;
    logic [COUNT_W-1:0] slot_plus_one;
    logic               in_xfer;

    assign out_slot      = m_axis_tdata[SLOT_W-1:0];
    assign out_count     = m_axis_tdata[SLOT_W +: COUNT_W];
    assign slot_plus_one = COUNT_W'(out_slot) + COUNT_W'(1);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("second input taken while an item is in work");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CLEAR) |->
            (out_slot == '0) && (out_count == '0))
        else $error("clear result not empty");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (out_slot == '0))
        else $error("full drop reports nonzero slot");

    a_append_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_APPEND) |->
            (out_count[SLOT_W-1:0] == slot_plus_one[SLOT_W-1:0]))
        else $error("append not at the table tail");

endmodule

bind sorted_range_set_insert_core srsi_checker u_srsi_checker (.*);

`default_nettype wire
